// ----- src/cbh_pkg.sv -----
// Shared types and constants for the CBOR item head encoder.
`default_nettype none
package cbh_pkg;

    localparam int POS_W            = 13;
    localparam int MAX_BUFFER_DEF   = 4096;
    localparam logic [POS_W-1:0] BUF_SIZE_RESET = 13'd4096;

    localparam logic [2:0] MODE_UINT    = 3'd0;
    localparam logic [2:0] MODE_MAP     = 3'd1;
    localparam logic [2:0] MODE_TEXT    = 3'd2;
    localparam logic [2:0] MODE_BYTES   = 3'd3;
    localparam logic [2:0] MODE_PAYLOAD = 3'd4;
    localparam logic [2:0] MODE_RESTART = 3'd5;

    localparam logic [2:0] MAJOR_UINT  = 3'd0;
    localparam logic [2:0] MAJOR_BYTES = 3'd2;
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;
    localparam logic [2:0] MAJOR_MAP   = 3'd5;

    localparam logic [4:0] AI_MAX_IMM = 5'd23;
    localparam logic [4:0] AI_ONE     = 5'd24;
    localparam logic [4:0] AI_TWO     = 5'd25;
    localparam logic [4:0] AI_FOUR    = 5'd26;
    localparam logic [4:0] AI_EIGHT   = 5'd27;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [3:0]  cnt;
        logic        has_bytes;
        logic [7:0]  head;
        logic [63:0] tail;
        logic [1:0]  status;
    } plan_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } beat_t;

endpackage
`default_nettype wire

// ----- src/cbh_plan.sv -----
// Command decode: head byte, tail length and status plan for one word.
`default_nettype none
module cbh_plan #(
    parameter int MAX_BUFFER_BYTES = cbh_pkg::MAX_BUFFER_DEF
) (
    input  wire logic [2:0]                mode,
    input  wire logic [63:0]               value,
    input  wire logic [7:0]                data_byte,
    input  wire logic [cbh_pkg::POS_W-1:0] buffer_size,
    input  wire logic [cbh_pkg::POS_W-1:0] pos,
    output cbh_pkg::plan_t                 plan
);

    logic [cbh_pkg::POS_W-1:0] cap;
    logic [cbh_pkg::POS_W-1:0] room0;
    logic [cbh_pkg::POS_W-1:0] room1;
    logic [cbh_pkg::POS_W-1:0] room_after;
    logic [cbh_pkg::POS_W-1:0] n_ext;
    logic [4:0]                ai;
    logic [3:0]                n;
    logic [2:0]                major;
    logic [63:0]               tail_sh;
    logic                      is_str;
    logic                      str_oom;

    always_comb begin
        cap   = (int'(buffer_size) > MAX_BUFFER_BYTES) ?
                cbh_pkg::POS_W'(MAX_BUFFER_BYTES) : buffer_size;
        room0 = (pos >= cap) ? '0 : cap - pos;
        room1 = room0 - cbh_pkg::POS_W'(1);
    end

    always_comb begin
        if (value[63:5] == '0 && value[4:0] <= cbh_pkg::AI_MAX_IMM) begin
            ai = value[4:0];
            n  = 4'd0;
        end else if (value[63:8] == '0) begin
            ai = cbh_pkg::AI_ONE;
            n  = 4'd1;
        end else if (value[63:16] == '0) begin
            ai = cbh_pkg::AI_TWO;
            n  = 4'd2;
        end else if (value[63:32] == '0) begin
            ai = cbh_pkg::AI_FOUR;
            n  = 4'd4;
        end else begin
            ai = cbh_pkg::AI_EIGHT;
            n  = 4'd8;
        end
        n_ext = cbh_pkg::POS_W'(n);
    end

    always_comb begin
        case (n)
            4'd1:    tail_sh = {value[7:0], 56'd0};
            4'd2:    tail_sh = {value[15:0], 48'd0};
            4'd4:    tail_sh = {value[31:0], 32'd0};
            default: tail_sh = value;
        endcase
    end

    always_comb begin
        unique case (mode)
            cbh_pkg::MODE_MAP:   major = cbh_pkg::MAJOR_MAP;
            cbh_pkg::MODE_TEXT:  major = cbh_pkg::MAJOR_TEXT;
            cbh_pkg::MODE_BYTES: major = cbh_pkg::MAJOR_BYTES;
            default:             major = cbh_pkg::MAJOR_UINT;
        endcase
        is_str     = (mode == cbh_pkg::MODE_TEXT) || (mode == cbh_pkg::MODE_BYTES);
        room_after = (n == 4'd0) ? room1 : room1 - n_ext;
        str_oom    = is_str && ((|value[63:cbh_pkg::POS_W]) ||
                     (value[cbh_pkg::POS_W-1:0] > room_after));
    end

    always_comb begin
        plan = '0;
        unique case (mode) inside
            cbh_pkg::MODE_PAYLOAD: begin
                plan.cnt = 4'd1;
                if (room0 == '0) begin
                    plan.status = cbh_pkg::STATUS_OOM;
                end else begin
                    plan.has_bytes = 1'b1;
                    plan.head      = data_byte;
                end
            end
            cbh_pkg::MODE_RESTART: begin
                plan.cnt = 4'd1;
            end
            cbh_pkg::MODE_UINT, cbh_pkg::MODE_MAP,
            cbh_pkg::MODE_TEXT, cbh_pkg::MODE_BYTES: begin
                plan.cnt = 4'd1;
                if (mode == cbh_pkg::MODE_MAP && (&value)) begin
                    plan.status = cbh_pkg::STATUS_UNKNOWN;
                end else if (room0 == '0) begin
                    plan.status = cbh_pkg::STATUS_OOM;
                end else begin
                    plan.has_bytes = 1'b1;
                    plan.head      = {major, ai};
                    if (n == 4'd0) begin
                        plan.status = str_oom ? cbh_pkg::STATUS_OOM : cbh_pkg::STATUS_OK;
                    end else if (room1 < n_ext) begin
                        plan.status = cbh_pkg::STATUS_OOM;
                    end else begin
                        plan.cnt    = n + 4'd1;
                        plan.tail   = tail_sh;
                        plan.status = str_oom ? cbh_pkg::STATUS_OOM : cbh_pkg::STATUS_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/cbh_serial.sv -----
// Byte serializer: head byte then tail bytes shifted out most significant first.
`default_nettype none
module cbh_serial (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire cbh_pkg::plan_t plan,
    input  wire logic    adv,
    output logic         busy,
    output cbh_pkg::beat_t beat
);

    logic [3:0]  cnt_reg,    cnt_next;
    logic        first_reg,  first_next;
    logic        has_reg,    has_next;
    logic [7:0]  head_reg,   head_next;
    logic [63:0] tail_reg,   tail_next;
    logic [1:0]  status_reg, status_next;

    always_comb begin
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        has_next    = has_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = status_reg;
        if (load) begin
            cnt_next    = plan.cnt;
            first_next  = 1'b1;
            has_next    = plan.has_bytes;
            head_next   = plan.head;
            tail_next   = plan.tail;
            status_next = plan.status;
        end else if (adv) begin
            cnt_next   = cnt_reg - 4'd1;
            first_next = 1'b0;
            if (!first_reg) begin
                tail_next = {tail_reg[55:0], 8'd0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
        has_reg    <= has_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        status_reg <= status_next;
    end

    always_comb begin
        busy            = (cnt_reg != '0);
        beat.byte_valid = has_reg;
        beat.out_byte   = !has_reg ? 8'd0 : (first_reg ? head_reg : tail_reg[63:56]);
        beat.last       = (cnt_reg == 4'd1);
        beat.status     = beat.last ? status_reg : cbh_pkg::STATUS_OK;
    end

endmodule
`default_nettype wire

// ----- src/cbor_head_encoder.sv -----
// Top level: CBOR item head encoder with buffer position tracking.
// Result words are registered in the byte serializer and then in the output register.
// Throughput: one result word per cycle while m_axis_tready allows; an item with
// r result words (0 to 9) holds s_axis_tready low until all have left the serializer.
// Reset: write position 0, buffer_size 4096, no result pending.
`default_nettype none
module cbor_head_encoder #(
    parameter int MAX_BUFFER_BYTES = cbh_pkg::MAX_BUFFER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data,       // buffer_size
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // value[63:0], data_byte[71:64]
    input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_byte[7:0], status[9:8], used_bytes[22:10]
    output logic             m_axis_tuser,   // byte_valid
    output logic             m_axis_tlast
);

    logic [cbh_pkg::POS_W-1:0] buf_size_reg, buf_size_next;
    logic [cbh_pkg::POS_W-1:0] pos_reg,      pos_next;
    logic                      m_valid_reg,  m_valid_next;
    cbh_pkg::beat_t            m_beat_reg,   m_beat_next;
    logic [cbh_pkg::POS_W-1:0] m_used_reg,   m_used_next;

    cbh_pkg::plan_t plan;
    cbh_pkg::beat_t beat;
    logic           busy;
    logic           accept;
    logic           take;

    cbh_plan #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_plan (
        .mode        (s_axis_tuser),
        .value       (s_axis_tdata[63:0]),
        .data_byte   (s_axis_tdata[71:64]),
        .buffer_size (buf_size_reg),
        .pos         (pos_reg),
        .plan        (plan)
    );

    cbh_serial u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .plan    (plan),
        .adv     (take),
        .busy    (busy),
        .beat    (beat)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && !busy;
    assign take          = busy && (!m_valid_reg || m_axis_tready);

    always_comb begin
        buf_size_next = buf_size_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg;
        m_beat_next   = m_beat_reg;
        m_used_next   = m_used_reg;
        if (cfg_valid) begin
            buf_size_next = cfg_data;
        end
        if (accept && s_axis_tuser == cbh_pkg::MODE_RESTART) begin
            pos_next = '0;
        end
        if (take) begin
            m_valid_next = 1'b1;
            m_beat_next  = beat;
            m_used_next  = pos_reg + cbh_pkg::POS_W'(beat.byte_valid);
            pos_next     = m_used_next;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg <= cbh_pkg::BUF_SIZE_RESET;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            buf_size_reg <= buf_size_next;
            pos_reg      <= pos_next;
            m_valid_reg  <= m_valid_next;
        end
        m_beat_reg <= m_beat_next;
        m_used_reg <= m_used_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_used_reg, m_beat_reg.status, m_beat_reg.out_byte};
    assign m_axis_tuser  = m_beat_reg.byte_valid;
    assign m_axis_tlast  = m_beat_reg.last;

endmodule
`default_nettype wire
